[rtl/core/pngunf_pkg.sv]
// shared types and constants for the png scanline unfilter
`timescale 1ns / 1ps

package pngunf_pkg;

    localparam int MAX_ROW_BYTES = 8192;
    localparam int COL_W         = $clog2(MAX_ROW_BYTES);
    localparam int CNT_W         = $clog2(MAX_ROW_BYTES + 1);
    localparam int BPP_W         = 3;
    localparam int ROWB_W        = 14;
    localparam int ROWS_W        = 16;
    localparam int CMP_W         = (CNT_W > ROWB_W) ? CNT_W : ROWB_W;
    localparam int ADDR_W        = 4;
    localparam int DATA_W        = 32;

    localparam logic [1:0] REG_BPP       = 2'd0;
    localparam logic [1:0] REG_ROW_BYTES = 2'd1;
    localparam logic [1:0] REG_ROWS      = 2'd2;

    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } t_filter;

    typedef struct packed {
        logic [BPP_W-1:0]  bpp;
        logic [ROWB_W-1:0] row_bytes;
        logic [ROWS_W-1:0] image_rows;
    } t_cfg;

endpackage

[rtl/core/png_scanline_unfilter.sv]
// png scanline unfilter top level: row sequencing, line store and output register
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   in      | i_in_valid, o_in_stall, i_filtered_byte   | in
//   out     | o_out_valid, i_out_stall, o_pixel_byte,   | out
//           | o_row_end, o_image_end, o_bad_filter      |
//   cfg     | psel, penable, pwrite, paddr, pwdata,     | in
//           | prdata, pready                            |
//
// one beat per cycle sustained while the output is not stalled; a data byte is registered in the
// predictor stage while the registered read of the line store completes, then enters the output register.
// the line store needs no clearing; row zero reads its above bytes as zero.
// a stall on the output holds the predictor stage and then stalls the input.
// reset is synchronous and active low.
`timescale 1ns / 1ps

module png_scanline_unfilter
    import pngunf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [7:0]        i_filtered_byte,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [7:0]        o_pixel_byte,
    output logic              o_row_end,
    output logic              o_image_end,
    output logic              o_bad_filter,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    t_cfg cfg;

    // front state
    logic [COL_W-1:0]  r_col;
    logic [ROWS_W-1:0] r_row;
    logic              r_await;
    logic              r_fault;
    t_filter           r_filter;

    // predictor stage
    logic              r_s1_valid;
    logic [7:0]        r_s1_byte;
    logic [COL_W-1:0]  r_s1_col;
    t_filter           r_s1_filter;
    logic              r_s1_row0;
    logic              r_s1_row_end;
    logic              r_s1_img_end;
    logic              r_s1_bad;
    logic [31:0]       r_left;
    logic [31:0]       r_upleft;

    // output register
    logic              r_out_valid;
    logic [7:0]        r_out_byte;
    logic              r_out_row_end;
    logic              r_out_img_end;
    logic              r_out_bad;

    logic              s1_adv;
    logic              in_acc;
    logic              active;
    logic              take_filter;
    logic              take_data;
    logic              bad_code;
    logic [BPP_W-1:0]  bpp_c;
    logic [1:0]        sel;
    logic [CMP_W-1:0]  rb_c;
    logic [CMP_W-1:0]  col_next;
    logic              row_done;
    logic [ROWS_W-1:0] row_next;
    logic [7:0]        ram_rdata;
    logic              first_px;
    logic [7:0]        a;
    logic [7:0]        b;
    logic [7:0]        c;
    logic [7:0]        x;

    pngunf_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // clamp registers
    always_comb begin
        if (cfg.bpp == '0) begin
            bpp_c = BPP_W'(1);
        end else if (cfg.bpp > BPP_W'(4)) begin
            bpp_c = BPP_W'(4);
        end else begin
            bpp_c = cfg.bpp;
        end
        sel = 2'(bpp_c - BPP_W'(1));
        if (cfg.row_bytes == '0) begin
            rb_c = CMP_W'(1);
        end else if (CMP_W'(cfg.row_bytes) > CMP_W'(MAX_ROW_BYTES)) begin
            rb_c = CMP_W'(MAX_ROW_BYTES);
        end else begin
            rb_c = CMP_W'(cfg.row_bytes);
        end
    end

    assign s1_adv      = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_s1_valid && !s1_adv;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign active      = !r_fault && (r_row < cfg.image_rows);
    assign bad_code    = !(i_filtered_byte inside {[8'd0:8'd4]});
    assign take_filter = in_acc && active && r_await;
    assign take_data   = in_acc && active && !r_await;
    assign col_next    = CMP_W'(r_col) + CMP_W'(1);
    assign row_done    = col_next >= rb_c;
    assign row_next    = r_row + ROWS_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_await    <= 1'b1;
            r_fault    <= 1'b0;
            r_filter   <= FILT_NONE;
            r_s1_valid <= 1'b0;
        end else begin
            if (take_filter) begin
                if (bad_code) begin
                    r_fault <= 1'b1;
                end else begin
                    r_filter <= t_filter'(i_filtered_byte[2:0]);
                    r_await  <= 1'b0;
                    r_col    <= '0;
                end
            end else if (take_data) begin
                if (row_done) begin
                    r_row   <= row_next;
                    r_await <= 1'b1;
                    r_col   <= '0;
                end else begin
                    r_col <= col_next[COL_W-1:0];
                end
            end
            if ((take_filter && bad_code) || take_data) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((take_filter && bad_code) || take_data) begin
            r_s1_byte    <= i_filtered_byte;
            r_s1_col     <= r_col;
            r_s1_filter  <= r_filter;
            r_s1_row0    <= (r_row == '0);
            r_s1_row_end <= take_data && row_done;
            r_s1_img_end <= take_data && row_done && (row_next >= cfg.image_rows);
            r_s1_bad     <= take_filter;
        end
    end

    pngunf_ram #(
        .WIDTH (8),
        .DEPTH (MAX_ROW_BYTES)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (s1_adv && !r_s1_bad),
        .i_waddr (r_s1_col),
        .i_wdata (x),
        .i_re    (take_data),
        .i_raddr (r_col),
        .o_rdata (ram_rdata)
    );

    // left neighbors exist only once a whole pixel lies behind in this row
    assign first_px = r_s1_col < COL_W'(bpp_c);

    always_comb begin
        a = first_px ? 8'd0 : r_left[8*sel +: 8];
        b = r_s1_row0 ? 8'd0 : ram_rdata;
        c = (first_px || r_s1_row0) ? 8'd0 : r_upleft[8*sel +: 8];
    end

    pngunf_pred u_pred (
        .i_filter (r_s1_filter),
        .i_raw    (r_s1_byte),
        .i_a      (a),
        .i_b      (b),
        .i_c      (c),
        .o_x      (x)
    );

    always_ff @(posedge i_clk) begin
        if (s1_adv && !r_s1_bad) begin
            r_left   <= {r_left[23:0], x};
            r_upleft <= {r_upleft[23:0], b};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_byte    <= r_s1_bad ? 8'd0 : x;
            r_out_row_end <= r_s1_row_end;
            r_out_img_end <= r_s1_img_end;
            r_out_bad     <= r_s1_bad;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_pixel_byte = r_out_byte;
    assign o_row_end    = r_out_row_end;
    assign o_image_end  = r_out_img_end;
    assign o_bad_filter = r_out_bad;

endmodule

[rtl/core/pngunf_ram.sv]
// generic single-port-write, single-port-read ram with registered read
`timescale 1ns / 1ps

module pngunf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/pngunf_cfg.sv]
// apb configuration registers for the png scanline unfilter
`timescale 1ns / 1ps

module pngunf_cfg
    import pngunf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg       r_cfg;
    t_cfg       n_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (reg_idx)
                REG_BPP:       n_cfg.bpp        = pwdata[BPP_W-1:0];
                REG_ROW_BYTES: n_cfg.row_bytes  = pwdata[ROWB_W-1:0];
                REG_ROWS:      n_cfg.image_rows = pwdata[ROWS_W-1:0];
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bpp        <= BPP_W'(4);
            r_cfg.row_bytes  <= ROWB_W'(8192);
            r_cfg.image_rows <= ROWS_W'(1);
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (reg_idx)
            REG_BPP:       prdata = DATA_W'(r_cfg.bpp);
            REG_ROW_BYTES: prdata = DATA_W'(r_cfg.row_bytes);
            REG_ROWS:      prdata = DATA_W'(r_cfg.image_rows);
            default:       prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/core/pngunf_pred.sv]
// filter predictor and byte reconstruction
`timescale 1ns / 1ps

module pngunf_pred
    import pngunf_pkg::*;
(
    input  t_filter    i_filter,
    input  logic [7:0] i_raw,
    input  logic [7:0] i_a,
    input  logic [7:0] i_b,
    input  logic [7:0] i_c,
    output logic [7:0] o_x
);

    logic signed [9:0] sa;
    logic signed [9:0] sb;
    logic signed [9:0] sc;
    logic signed [9:0] da;
    logic signed [9:0] db;
    logic signed [9:0] dc;
    logic        [9:0] pa;
    logic        [9:0] pb;
    logic        [9:0] pc;
    logic        [8:0] avg_sum;
    logic        [7:0] paeth;
    logic        [7:0] pred;

    always_comb begin
        sa = signed'({2'b00, i_a});
        sb = signed'({2'b00, i_b});
        sc = signed'({2'b00, i_c});
        // p - a, p - b, p - c with p = a + b - c
        da = sb - sc;
        db = sa - sc;
        dc = sa + sb - sc - sc;
        pa = (da < 0) ? 10'(-da) : 10'(da);
        pb = (db < 0) ? 10'(-db) : 10'(db);
        pc = (dc < 0) ? 10'(-dc) : 10'(dc);
        if (pa <= pb && pa <= pc) begin
            paeth = i_a;
        end else if (pb <= pc) begin
            paeth = i_b;
        end else begin
            paeth = i_c;
        end
        avg_sum = {1'b0, i_a} + {1'b0, i_b};
        case (i_filter)
            FILT_SUB:   pred = i_a;
            FILT_UP:    pred = i_b;
            FILT_AVG:   pred = avg_sum[8:1];
            FILT_PAETH: pred = paeth;
            default:    pred = 8'd0;
        endcase
        o_x = i_raw + pred;
    end

endmodule

[tb/testbench.sv]
// self-checking testbench for the png scanline unfilter: row streams, register settings, faults
`timescale 1ns / 1ps

module testbench;
    import pngunf_pkg::*;

    localparam int RUN_LIMIT    = 6000000;
    localparam int SETTLE       = 10;
    localparam int RANDOM_ITEMS = 350;
    localparam int FIRST_ROW    = 200;

    typedef struct packed {
        logic [7:0] pix;
        logic       row_end;
        logic       image_end;
        logic       bad_filter;
    } t_pixel_out;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [7:0]        i_filtered_byte;
    logic              o_out_valid;
    logic              i_out_stall;
    logic [7:0]        o_pixel_byte;
    logic              o_row_end;
    logic              o_image_end;
    logic              o_bad_filter;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // predicted block state
    logic [7:0]        prev_row [MAX_ROW_BYTES];
    logic [31:0]       left_hist   = '0;
    logic [31:0]       upleft_hist = '0;
    int unsigned       col_cnt     = 0;
    logic [15:0]       rows_done   = '0;
    t_filter           row_filt    = FILT_NONE;
    bit                want_filter = 1'b1;
    bit                faulted     = 1'b0;
    logic [2:0]        cfg_bpp     = 3'd4;
    logic [13:0]       cfg_rowb    = 14'd8192;
    logic [15:0]       cfg_rows    = 16'd1;

    t_pixel_out        pixel_q[$];
    int                errors      = 0;
    int                live_items  = 0;
    int                calm_left   = 0;
    int                cycle_cnt   = 0;

    png_scanline_unfilter dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned row_len();
        if (cfg_rowb == 14'd0)
            return 1;
        if (cfg_rowb > MAX_ROW_BYTES)
            return MAX_ROW_BYTES;
        return cfg_rowb;
    endfunction

    function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                             input logic [7:0] c);
        int p, pa, pb, pc;
        p  = int'(a) + int'(b) - int'(c);
        pa = (p > int'(a)) ? p - int'(a) : int'(a) - p;
        pb = (p > int'(b)) ? p - int'(b) : int'(b) - p;
        pc = (p > int'(c)) ? p - int'(c) : int'(c) - p;
        if (pa <= pb && pa <= pc)
            return a;
        if (pb <= pc)
            return b;
        return c;
    endfunction

    task automatic unfilter_byte(input logic [7:0] fb);
        int unsigned bpp, rb, col;
        logic [7:0]  a, b, c, x, pred;
        logic [8:0]  sum;
        t_pixel_out  r;
        if (faulted || rows_done >= cfg_rows)
            return;
        live_items++;
        if (want_filter) begin
            if (fb > 8'd4) begin
                faulted = 1'b1;
                r = '{pix: 8'h00, row_end: 1'b0, image_end: 1'b0, bad_filter: 1'b1};
                pixel_q.push_back(r);
            end else begin
                row_filt    = t_filter'(fb[2:0]);
                want_filter = 1'b0;
                col_cnt     = 0;
                left_hist   = '0;
                upleft_hist = '0;
            end
            return;
        end
        bpp = (cfg_bpp == 3'd0) ? 1 : ((cfg_bpp > 3'd4) ? 4 : cfg_bpp);
        rb  = row_len();
        col = (col_cnt >= MAX_ROW_BYTES) ? MAX_ROW_BYTES - 1 : col_cnt;
        a   = left_hist[(bpp - 1) * 8 +: 8];
        c   = (rows_done == 16'd0) ? 8'h00 : upleft_hist[(bpp - 1) * 8 +: 8];
        b   = (rows_done == 16'd0) ? 8'h00 : prev_row[col];
        sum = {1'b0, a} + {1'b0, b};
        case (row_filt)
            FILT_SUB:   pred = a;
            FILT_UP:    pred = b;
            FILT_AVG:   pred = sum[8:1];
            FILT_PAETH: pred = paeth_pick(a, b, c);
            default:    pred = 8'h00;
        endcase
        x           = fb + pred;
        prev_row[col] = x;
        left_hist   = {left_hist[23:0], x};
        upleft_hist = {upleft_hist[23:0], b};
        col_cnt     = col + 1;
        r = '{pix: x, row_end: 1'b0, image_end: 1'b0, bad_filter: 1'b0};
        if (col_cnt >= rb) begin
            rows_done   = rows_done + 16'd1;
            r.row_end   = 1'b1;
            r.image_end = (rows_done >= cfg_rows);
            want_filter = 1'b1;
            col_cnt     = 0;
        end
        pixel_q.push_back(r);
    endtask

    function automatic int pick_gap();
        int r;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r == 0) begin
            calm_left = $urandom_range(20, 100);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] pick_data(input bit narrow);
        if (!narrow)
            return 8'($urandom_range(0, 255));
        if ($urandom_range(0, 1) == 0)
            return 8'($urandom_range(0, 3));
        return 8'hFF - 8'($urandom_range(0, 3));
    endfunction

    task automatic send_byte(input logic [7:0] v);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_filtered_byte <= v;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        unfilter_byte(v);
    endtask

    task automatic send_row(input t_filter f, input bit narrow);
        int unsigned n;
        n = row_len();
        send_byte({5'd0, f});
        repeat (n) send_byte(pick_data(narrow));
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        logic [31:0] mask;
        case (idx)
            REG_BPP:       mask = 32'h0000_0007;
            REG_ROW_BYTES: mask = 32'h0000_3FFF;
            default:       mask = 32'h0000_FFFF;
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        // read back through a second transfer
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== (val & mask)) begin
            $display("%0t: register %0d read back expected %h actual %h",
                     $time, idx, val & mask, prdata);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_BPP:       cfg_bpp  = val[2:0];
            REG_ROW_BYTES: cfg_rowb = val[13:0];
            default:       cfg_rows = val[15:0];
        endcase
    endtask

    // first row starts at the register reset values and is cut short mid-row;
    // it writes the line store up to the longest row used later
    task automatic test_reset_defaults();
        send_byte({5'd0, FILT_PAETH});
        repeat (FIRST_ROW - 1) send_byte(pick_data(1'b0));
        drain_results();
        reg_write(REG_ROW_BYTES, 32'(FIRST_ROW));
        send_byte(pick_data(1'b0));
        repeat (3) send_byte(pick_data(1'b0));
        drain_results();
    endtask

    task automatic test_each_filter();
        reg_write(REG_BPP, 32'd1);
        reg_write(REG_ROW_BYTES, 32'd4);
        reg_write(REG_ROWS, 32'(rows_done) + 32'd5);
        for (int f = 0; f < 5; f++) begin
            send_byte(8'(f));
            send_byte(8'h00);
            send_byte(8'hFF);
            send_byte(8'h80);
            send_byte(8'h7F);
        end
        drain_results();
    endtask

    task automatic test_pixel_sizes();
        logic [2:0] sizes [8];
        sizes = '{3'd1, 3'd2, 3'd3, 3'd4, 3'd0, 3'd5, 3'd6, 3'd7};
        for (int k = 0; k < 8; k++) begin
            reg_write(REG_BPP, 32'(sizes[k]));
            reg_write(REG_ROW_BYTES, $urandom_range(1, 24));
            reg_write(REG_ROWS, 32'(rows_done) + 32'd3);
            for (int i = 0; i < 3; i++)
                send_row(t_filter'((k + i) % 5), $urandom_range(0, 2) == 0);
            drain_results();
        end
    endtask

    task automatic test_image_limits();
        reg_write(REG_ROWS, 32'd0);
        repeat (4) send_byte(pick_data(1'b0));
        drain_results();
        reg_write(REG_ROWS, 32'(rows_done));
        repeat (3) send_byte(pick_data(1'b0));
        drain_results();
        reg_write(REG_BPP, 32'd3);
        reg_write(REG_ROW_BYTES, 32'd0);
        reg_write(REG_ROWS, 32'(rows_done) + 32'd2);
        send_row(FILT_SUB, 1'b0);
        send_row(FILT_PAETH, 1'b0);
        send_byte(8'h01);
        drain_results();
    endtask

    task automatic test_pause_mid_row();
        reg_write(REG_BPP, 32'd2);
        reg_write(REG_ROW_BYTES, 32'd10);
        reg_write(REG_ROWS, 32'(rows_done) + 32'd2);
        send_byte({5'd0, FILT_SUB});
        repeat (5) send_byte(pick_data(1'b0));
        drain_results();
        repeat (5) send_byte(pick_data(1'b0));
        send_row(FILT_PAETH, 1'b0);
        drain_results();
    endtask

    task automatic test_random_images();
        int          start;
        int unsigned nrows;
        logic [31:0] rb;
        start = live_items;
        while (live_items - start < RANDOM_ITEMS) begin
            drain_results();
            if ($urandom_range(0, 9) < 8)
                reg_write(REG_BPP, $urandom_range(1, 4));
            else
                reg_write(REG_BPP, $urandom_range(0, 7));
            case ($urandom_range(0, 15))
                0:       rb = $urandom_range(0, 3);
                1:       rb = $urandom_range(64, FIRST_ROW);
                default: rb = $urandom_range(1, 32);
            endcase
            reg_write(REG_ROW_BYTES, rb);
            nrows = $urandom_range(1, 5);
            if ($urandom_range(0, 15) == 0)
                reg_write(REG_ROWS, 32'hFFFF);
            else
                reg_write(REG_ROWS, 32'(rows_done) + nrows);
            repeat (nrows) send_row(t_filter'($urandom_range(0, 4)), $urandom_range(0, 3) == 0);
            // trailing bytes past the last row
            if (rows_done >= cfg_rows && $urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) send_byte(pick_data(1'b0));
        end
        drain_results();
    endtask

    // fault is sticky until reset, so this runs last
    task automatic test_bad_filter();
        reg_write(REG_BPP, 32'd4);
        reg_write(REG_ROW_BYTES, 32'd6);
        reg_write(REG_ROWS, 32'(rows_done) + 32'd3);
        send_row(FILT_UP, 1'b0);
        send_byte(8'($urandom_range(5, 255)));
        send_byte({5'd0, FILT_NONE});
        repeat (5) send_byte(pick_data(1'b0));
        drain_results();
    endtask

    initial begin
        int left;
        bit hold;
        i_out_stall <= 1'b0;
        left = 0;
        hold = 1'b0;
        forever begin
            @(posedge i_clk);
            if (left == 0) begin
                hold = !hold;
                if (hold) begin
                    case ($urandom_range(0, 19))
                        0:       left = $urandom_range(20, 40);
                        1, 2, 3, 4, 5: left = $urandom_range(3, 8);
                        default: left = $urandom_range(1, 2);
                    endcase
                end else begin
                    case ($urandom_range(0, 9))
                        0:       left = $urandom_range(50, 200);
                        1, 2, 3: left = $urandom_range(5, 30);
                        default: left = $urandom_range(1, 4);
                    endcase
                end
            end
            left--;
            i_out_stall <= hold;
        end
    end

    always @(posedge i_clk) begin : check_pixels
        t_pixel_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pixel_q.size() == 0) begin
                $display("%0t: unexpected beat pixel %h row_end %b image_end %b bad_filter %b",
                         $time, o_pixel_byte, o_row_end, o_image_end, o_bad_filter);
                errors++;
            end else begin
                want = pixel_q.pop_front();
                if (o_pixel_byte !== want.pix) begin
                    $display("%0t: pixel_byte expected %h actual %h",
                             $time, want.pix, o_pixel_byte);
                    errors++;
                end
                if (o_row_end !== want.row_end) begin
                    $display("%0t: row_end expected %b actual %b",
                             $time, want.row_end, o_row_end);
                    errors++;
                end
                if (o_image_end !== want.image_end) begin
                    $display("%0t: image_end expected %b actual %b",
                             $time, want.image_end, o_image_end);
                    errors++;
                end
                if (o_bad_filter !== want.bad_filter) begin
                    $display("%0t: bad_filter expected %b actual %b",
                             $time, want.bad_filter, o_bad_filter);
                    errors++;
                end
            end
        end
    end

    initial begin
        while (cycle_cnt < RUN_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("FAIL png_scanline_unfilter");
        $finish;
    end

    initial begin
        i_rst_n         <= 1'b0;
        i_in_valid      <= 1'b0;
        i_filtered_byte <= 8'h00;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_each_filter();
        test_pixel_sizes();
        test_image_limits();
        test_pause_mid_row();
        test_random_images();
        test_bad_filter();

        drain_results();
        if (errors == 0)
            $display("PASS png_scanline_unfilter");
        else
            $display("FAIL png_scanline_unfilter");
        $finish;
    end

endmodule
